FILE: rtl/slre_pkg.sv
// ----------------------------------------------------------------------------
// slre_pkg
// shared constants and types of the subflow loss rate estimator
// ----------------------------------------------------------------------------
package slre_pkg;
  localparam int unsigned Subflows = 8;
  localparam int unsigned SfW = 3;
  localparam int unsigned IdxW = (Subflows > 1) ? $clog2(Subflows) : 1;
  localparam logic [31:0] TtUnusable = 32'hffff_fffd;
  localparam logic [31:0] RedundantScale = 32'd100;

  localparam logic [1:0] OpSeed = 2'd0;
  localparam logic [1:0] OpEvent = 2'd1;
  localparam logic [1:0] OpEval = 2'd2;

  localparam logic [2:0] CaOpen = 3'd0;
  localparam logic [2:0] CaCwr = 3'd2;
  localparam logic [2:0] CaRecovery = 3'd3;
  localparam logic [2:0] CaLoss = 3'd4;

  localparam logic RegShift = 1'b0;
  localparam logic RegThresh = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [SfW-1:0] subflow;
    logic [2:0] ca_state;
    logic [7:0] retransmit_count;
    logic [31:0] unacked_seq;
    logic [15:0] seg_size;
    logic [31:0] smoothed_rtt;
  } req_t;

  typedef struct packed {
    logic [31:0] transfer_time;
    logic redundant;
    logic has_lost;
  } rsp_t;

  typedef struct packed {
    logic [31:0] prev_mark;
    logic [31:0] last_mark;
    logic [31:0] rate;
    logic seen;
    logic [2:0] cstate;
    logic cls;
  } entry_t;

  typedef struct packed {
    logic [0:0] index;
    logic [7:0] data;
  } cfg_t;
endpackage

FILE: rtl/slre_if.sv
// ----------------------------------------------------------------------------
// slre_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface slre_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/slre_div.sv
// ----------------------------------------------------------------------------
// slre_div
// 64 by 32 bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module slre_div
  import slre_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [6:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  assign trial = {rem_q[31:0], quo_q[63]};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quotient_o = quo_q;
endmodule

FILE: rtl/subflow_loss_rate_estimator.sv
// ----------------------------------------------------------------------------
// subflow_loss_rate_estimator
// per-subflow loss marks and inverse loss rate held in one table memory
// sequence: StRead, StCalc, StOut per request; an evaluate adds StMul and StCmp, and StDiv when it divides
// throughput: one request at a time, the next taken only after the response
// leaves; the 64-step divider sets the worst case
// reset: valid bits clear every entry at once, registers return to defaults
// ----------------------------------------------------------------------------
module subflow_loss_rate_estimator
  import slre_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  slre_if.sink req_i,
  slre_if.sink cfg_i,
  slre_if.source rsp_o
);
  typedef enum logic [2:0] {
    StIdle, StRead, StCalc, StMul, StCmp, StDiv, StOut
  } state_e;

  state_e state_q;
  req_t req_q;
  entry_t ent_q, mem_rd_q;
  entry_t mem [Subflows];
  logic [Subflows-1:0] vld_q;
  logic vld_rd_q;
  logic [4:0] shift_q;
  logic [7:0] thresh_q;
  logic [31:0] tt_q;
  logic [63:0] prod_q;
  logic [31:0] thr_prod_q;
  logic [31:0] scaled_mss_q;
  logic [31:0] divisor_q;
  logic div_start_q;
  logic div_done;
  logic [63:0] div_quo;
  logic wr_q;
  logic rsp_valid_q;
  rsp_t rsp_q;
  logic in_range;
  logic [IdxW-1:0] idx;
  entry_t cur, nxt;
  logic [31:0] sample, gap, rate_g, sum32;
  logic flip;

  assign idx = req_q.subflow[IdxW-1:0];
  assign in_range = ({29'd0, req_q.subflow} < 32'(Subflows));
  assign cur = vld_rd_q ? mem_rd_q : '0;

  assign req_i.ready = (state_q == StIdle) && !rsp_valid_q;
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  slre_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start_q),
    .dividend_i(prod_q),
    .divisor_i(divisor_q),
    .done_o(div_done),
    .quotient_o(div_quo)
  );

  always_comb begin
    nxt = cur;
    flip = 1'b0;
    sample = '0;
    gap = req_q.unacked_seq - cur.last_mark;
    rate_g = (gap > cur.rate) ? gap : cur.rate;
    sum32 = ent_q.rate + {16'd0, req_q.seg_size};
    unique case (req_q.op)
      OpSeed: begin
        if (cur.prev_mark == '0 && cur.last_mark == '0) begin
          nxt.prev_mark = req_q.unacked_seq;
          nxt.last_mark = req_q.unacked_seq;
          nxt.cstate = CaOpen;
        end
      end
      OpEvent: begin
        flip = (cur.last_mark == req_q.unacked_seq) &&
               ((cur.cstate == CaRecovery && req_q.ca_state == CaLoss) ||
                (cur.cstate == CaLoss && req_q.ca_state == CaRecovery));
        if ((req_q.ca_state == CaCwr || req_q.ca_state == CaRecovery ||
             req_q.ca_state == CaLoss) && req_q.retransmit_count == '0 && !flip) begin
          sample = req_q.unacked_seq - cur.last_mark + {16'd0, req_q.seg_size};
          nxt.prev_mark = cur.last_mark;
          nxt.last_mark = req_q.unacked_seq;
          nxt.rate = cur.seen ? ((sample >> shift_q) + cur.rate - (cur.rate >> shift_q))
                              : {sample[29:0], 2'b00};
          nxt.seen = 1'b1;
          nxt.cstate = req_q.ca_state;
        end
      end
      OpEval: begin
        if (cur.seen) nxt.rate = rate_g;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mem_rd_q <= mem[idx];
    if (wr_q && in_range) mem[idx] <= ent_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      vld_q <= '0;
      vld_rd_q <= 1'b0;
      shift_q <= '0;
      thresh_q <= 8'd5;
      rsp_valid_q <= 1'b0;
      wr_q <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      wr_q <= (state_q == StOut);
      div_start_q <= (state_q == StCmp) && ent_q.seen &&
                     (ent_q.rate > {16'd0, req_q.seg_size});
      if (cfg_i.valid) begin
        unique case (cfg_i.payload.index)
          RegShift: shift_q <= cfg_i.payload.data[4:0];
          RegThresh: thresh_q <= cfg_i.payload.data;
          default: ;
        endcase
      end
      if (rsp_valid_q && rsp_o.ready) rsp_valid_q <= 1'b0;
      if (wr_q && in_range) vld_q[idx] <= 1'b1;
      unique case (state_q)
        StIdle: begin
          if (req_i.valid && !rsp_valid_q) begin
            req_q <= req_i.payload;
            state_q <= StRead;
          end
        end
        StRead: begin
          vld_rd_q <= vld_q[idx];
          state_q <= StCalc;
        end
        StCalc: begin
          ent_q <= nxt;
          if (req_q.op == OpEval) begin
            tt_q <= req_q.smoothed_rtt >> 1;
            state_q <= StMul;
          end else begin
            tt_q <= '0;
            state_q <= StOut;
          end
        end
        StMul: begin
          prod_q <= 64'(sum32) * 64'(req_q.smoothed_rtt);
          divisor_q <= ent_q.rate - {16'd0, req_q.seg_size};
          thr_prod_q <= ent_q.rate * {24'd0, thresh_q};
          scaled_mss_q <= RedundantScale * {16'd0, req_q.seg_size};
          state_q <= StCmp;
        end
        StCmp: begin
          ent_q.cls <= ent_q.seen && (thr_prod_q < scaled_mss_q);
          if (ent_q.seen) begin
            if (ent_q.rate > {16'd0, req_q.seg_size}) begin
              state_q <= StDiv;
            end else begin
              tt_q <= TtUnusable;
              state_q <= StOut;
            end
          end else begin
            state_q <= StOut;
          end
        end
        StDiv: begin
          if (div_done) begin
            tt_q <= div_quo[32:1];
            state_q <= StOut;
          end
        end
        StOut: begin
          rsp_valid_q <= 1'b1;
          rsp_q.transfer_time <= in_range ? tt_q : '0;
          rsp_q.redundant <= in_range ? ent_q.cls : 1'b0;
          rsp_q.has_lost <= in_range ? ent_q.seen : 1'b0;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

FILE: verif/tb_subflow_loss_rate_estimator.sv
// ----------------------------------------------------------------------------
// tb_subflow_loss_rate_estimator
// drives seed, congestion event, evaluate and undefined-opcode requests with random gaps and
// back-pressure, predicts every response with a local table model and
// compares transfer time and both flags field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_subflow_loss_rate_estimator;
  import slre_pkg::*;

  localparam int unsigned SettleCycles = 200;

  logic clk_i;
  logic rst_ni;

  slre_if #(.payload_t(req_t)) req_ch ();
  slre_if #(.payload_t(cfg_t)) cfg_ch ();
  slre_if #(.payload_t(rsp_t)) rsp_ch ();

  subflow_loss_rate_estimator u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req_i(req_ch.sink),
    .cfg_i(cfg_ch.sink),
    .rsp_o(rsp_ch.source)
  );

  logic [31:0] m_prev [Subflows];
  logic [31:0] m_last [Subflows];
  logic [31:0] m_rate [Subflows];
  logic m_seen [Subflows];
  logic [2:0] m_cstate [Subflows];
  logic m_cls [Subflows];
  logic [4:0] m_shift;
  logic [7:0] m_thresh;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int errors;
  bit hold_send;
  int send_gap;
  int recv_gap;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic rsp_t predict_step(req_t q);
    rsp_t r;
    int s;
    logic [31:0] sample, gap, rate, mss;
    logic [63:0] dividend;
    r = '0;
    if (q.subflow >= Subflows) return r;
    s = q.subflow;
    mss = {16'd0, q.seg_size};
    if (q.op == OpSeed) begin
      if (m_prev[s] == 0 && m_last[s] == 0) begin
        m_prev[s] = q.unacked_seq;
        m_last[s] = q.unacked_seq;
        m_cstate[s] = CaOpen;
      end
    end else if (q.op == OpEvent) begin
      if ((q.ca_state == CaCwr || q.ca_state == CaRecovery || q.ca_state == CaLoss)
          && q.retransmit_count == 0
          && !(m_last[s] == q.unacked_seq &&
               ((m_cstate[s] == CaRecovery && q.ca_state == CaLoss) ||
                (m_cstate[s] == CaLoss && q.ca_state == CaRecovery)))) begin
        m_prev[s] = m_last[s];
        m_last[s] = q.unacked_seq;
        sample = m_last[s] - m_prev[s] + mss;
        if (m_seen[s]) m_rate[s] = (sample >> m_shift) + m_rate[s] - (m_rate[s] >> m_shift);
        else m_rate[s] = sample << 2;
        m_seen[s] = 1'b1;
        m_cstate[s] = q.ca_state;
      end
    end else if (q.op == OpEval) begin
      if (!m_seen[s]) begin
        r.transfer_time = q.smoothed_rtt >> 1;
      end else begin
        gap = q.unacked_seq - m_last[s];
        rate = m_rate[s];
        if (gap > rate) rate = gap;
        m_rate[s] = rate;
        if (rate > mss) begin
          dividend = {32'd0, rate + mss} * {32'd0, q.smoothed_rtt};
          r.transfer_time = 32'(dividend / {32'd0, rate - mss} >> 1);
        end else begin
          r.transfer_time = TtUnusable;
        end
      end
      m_cls[s] = m_seen[s] && (32'(m_rate[s] * {24'd0, m_thresh}) < RedundantScale * mss);
    end
    r.redundant = m_cls[s];
    r.has_lost = m_seen[s];
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      send_gap <= 0;
    end else if (req_ch.valid && !req_ch.ready) begin
    end else if (send_gap > 0) begin
      req_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_reqs.size() > 0 && !hold_send) begin
      req_ch.valid <= 1'b1;
      req_ch.payload <= pending_reqs[0];
      expected_rsps.push_back(predict_step(pending_reqs[0]));
      void'(pending_reqs.pop_front());
      send_gap <= rand_gap();
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // response monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response with none expected");
          errors++;
        end else begin
          if (rsp_ch.payload.transfer_time !== expected_rsps[0].transfer_time) begin
            $error("transfer_time exp %0h got %0h", expected_rsps[0].transfer_time,
                   rsp_ch.payload.transfer_time);
            errors++;
          end
          if (rsp_ch.payload.redundant !== expected_rsps[0].redundant) begin
            $error("redundant exp %0b got %0b", expected_rsps[0].redundant,
                   rsp_ch.payload.redundant);
            errors++;
          end
          if (rsp_ch.payload.has_lost !== expected_rsps[0].has_lost) begin
            $error("has_lost exp %0b got %0b", expected_rsps[0].has_lost,
                   rsp_ch.payload.has_lost);
            errors++;
          end
          void'(expected_rsps.pop_front());
        end
      end
      if (recv_gap > 0) begin
        rsp_ch.ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap <= rand_gap();
      end
    end
  end

  task automatic write_reg(logic idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= '{index: idx, data: val};
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == RegShift) m_shift = val[4:0];
    else m_thresh = val;
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !req_ch.valid && expected_rsps.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic req_t make_req(logic [1:0] op, int sf, logic [2:0] st,
                                    logic [7:0] rtx, logic [31:0] una,
                                    logic [15:0] mss, logic [31:0] rtt);
    req_t q;
    q.op = op;
    q.subflow = sf[SfW-1:0];
    q.ca_state = st;
    q.retransmit_count = rtx;
    q.unacked_seq = una;
    q.seg_size = mss;
    q.smoothed_rtt = rtt;
    return q;
  endfunction

  task automatic random_flow(int n);
    logic [31:0] una [Subflows];
    int sf, k;
    req_t q;
    for (int i = 0; i < Subflows; i++) una[i] = $urandom();
    for (int i = 0; i < n; i++) begin
      sf = $urandom_range(0, Subflows - 1);
      k = $urandom_range(0, 99);
      una[sf] = una[sf] + ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 200000));
      q = make_req(OpEval, sf, 3'($urandom_range(0, 4)),
                   ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'd0, una[sf],
                   ($urandom_range(0, 7) == 0) ? 16'($urandom()) :
                   16'($urandom_range(500, 1500)), $urandom());
      if (k < 8) q.op = OpSeed;
      else if (k < 50) q.op = OpEvent;
      else if (k < 95) q.op = OpEval;
      else q = req_t'({$urandom(), $urandom(), $urandom()});
      if (k >= 98) q.op = 2'd3;
      pending_reqs.push_back(q);
    end
  endtask

  initial begin
    errors = 0;
    hold_send = 0;
    m_shift = 5'd0;
    m_thresh = 8'd5;
    for (int i = 0; i < Subflows; i++) begin
      m_prev[i] = '0; m_last[i] = '0; m_rate[i] = '0;
      m_seen[i] = 1'b0; m_cstate[i] = CaOpen; m_cls[i] = 1'b0;
    end
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: seed, first loss, flip skip, evaluate extremes
    pending_reqs.push_back(make_req(OpEval, 0, CaOpen, 8'd0, 32'd0, 16'd0, 32'hffffffff));
    pending_reqs.push_back(make_req(OpSeed, 0, CaOpen, 8'd0, 32'd1000, 16'd1460, 32'd0));
    pending_reqs.push_back(make_req(OpSeed, 0, CaOpen, 8'd0, 32'd5, 16'd1460, 32'd0));
    pending_reqs.push_back(make_req(OpEvent, 0, CaRecovery, 8'd0, 32'd9000, 16'd1460, 0));
    pending_reqs.push_back(make_req(OpEvent, 0, CaLoss, 8'd0, 32'd9000, 16'd1460, 0));
    pending_reqs.push_back(make_req(OpEvent, 0, CaRecovery, 8'd0, 32'd9000, 16'd1460, 0));
    pending_reqs.push_back(make_req(OpEvent, 0, CaCwr, 8'd0, 32'd9000, 16'd1460, 0));
    pending_reqs.push_back(make_req(OpEvent, 0, CaLoss, 8'd255, 32'd20000, 16'd1460, 0));
    pending_reqs.push_back(make_req(OpEvent, 0, 3'd1, 8'd0, 32'd20000, 16'd1460, 0));
    pending_reqs.push_back(make_req(OpEvent, 0, 3'd7, 8'd0, 32'd20000, 16'd1460, 0));
    pending_reqs.push_back(make_req(OpEval, 0, CaOpen, 8'd0, 32'd9000, 16'd1460, 32'd1000));
    pending_reqs.push_back(make_req(OpEval, 0, CaOpen, 8'd0, 32'hffffffff, 16'hffff,
                                    32'hffffffff));
    pending_reqs.push_back(make_req(OpEval, 0, CaOpen, 8'd0, 32'd0, 16'hffff, 32'd7));
    pending_reqs.push_back(make_req(OpEvent, 1, CaLoss, 8'd0, 32'd0, 16'hffff, 0));
    pending_reqs.push_back(make_req(OpEval, 1, CaOpen, 8'd0, 32'd0, 16'hffff, 32'hffffffff));
    pending_reqs.push_back(make_req(2'd3, 1, 3'd7, 8'hff, 32'hffffffff, 16'hffff,
                                    32'hffffffff));
    pending_reqs.push_back(make_req(OpEvent, 7, CaCwr, 8'd0, 32'hffffffff, 16'd1, 0));
    pending_reqs.push_back(make_req(OpEval, 7, CaOpen, 8'd0, 32'hffffffff, 16'd1, 32'd3));
    drain();

    write_reg(RegShift, 8'd31);
    write_reg(RegThresh, 8'd0);
    random_flow(150);
    wait (pending_reqs.size() < 75);
    hold_send = 1;
    wait (expected_rsps.size() == 0 && !req_ch.valid);
    hold_send = 0;
    drain();
    write_reg(RegShift, 8'd3);
    write_reg(RegThresh, 8'd255);
    random_flow(150);
    drain();
    write_reg(RegShift, 8'($urandom_range(0, 31)));
    write_reg(RegThresh, 8'($urandom()));
    random_flow(130);
    drain();
    write_reg(RegShift, 8'd0);
    write_reg(RegThresh, 8'd5);
    random_flow(120);
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
